>>> src/ssod_pkg.sv
package ssod_pkg;

  typedef enum logic [4:0] {
    OP_INSERT    = 5'd0,
    OP_REMOVE    = 5'd1,
    OP_EXISTS    = 5'd2,
    OP_MIN       = 5'd3,
    OP_MIN_TAKE  = 5'd4,
    OP_MIN_DROP  = 5'd5,
    OP_MAX       = 5'd6,
    OP_MAX_TAKE  = 5'd7,
    OP_MAX_DROP  = 5'd8,
    OP_PRED      = 5'd9,
    OP_PRED_TAKE = 5'd10,
    OP_PRED_DROP = 5'd11,
    OP_SUCC      = 5'd12,
    OP_SUCC_TAKE = 5'd13,
    OP_SUCC_DROP = 5'd14,
    OP_READ_AT   = 5'd15,
    OP_CLEAR     = 5'd16
  } op_e;

  typedef enum logic [3:0] {
    K_INSERT,
    K_REMOVE,
    K_EXISTS,
    K_MIN,
    K_MAX,
    K_PRED,
    K_SUCC,
    K_READ,
    K_CLEAR,
    K_NONE
  } kind_e;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FALSE = 2'd1;
  localparam logic [1:0] ST_ERR   = 2'd2;

  // broadcast to every cell for the request under execution
  typedef struct packed {
    kind_e      kind;
    logic       take;
    logic [3:0] pos;
  } ctl_t;

  function automatic ctl_t decode_op(logic [4:0] op, logic [3:0] pos);
    ctl_t c;
    c.pos  = pos;
    c.take = 1'b0;
    c.kind = K_NONE;
    case (op)
      OP_INSERT: c.kind = K_INSERT;
      OP_REMOVE: begin
        c.kind = K_REMOVE;
        c.take = 1'b1;
      end
      OP_EXISTS: c.kind = K_EXISTS;
      OP_MIN, OP_MIN_TAKE, OP_MIN_DROP: c.kind = K_MIN;
      OP_MAX, OP_MAX_TAKE, OP_MAX_DROP: c.kind = K_MAX;
      OP_PRED, OP_PRED_TAKE, OP_PRED_DROP: c.kind = K_PRED;
      OP_SUCC, OP_SUCC_TAKE, OP_SUCC_DROP: c.kind = K_SUCC;
      OP_READ_AT: c.kind = K_READ;
      OP_CLEAR: c.kind = K_CLEAR;
      default: c.kind = K_NONE;
    endcase
    case (op)
      OP_MIN_TAKE, OP_MIN_DROP, OP_MAX_TAKE, OP_MAX_DROP,
      OP_PRED_TAKE, OP_PRED_DROP, OP_SUCC_TAKE, OP_SUCC_DROP: c.take = 1'b1;
      default: ;
    endcase
    return c;
  endfunction

endpackage

>>> src/sorted_set_ordered_dictionary_top.sv
// A request is registered when taken and executed against all cells once the
// result register is free; its result is registered and shown from the cycle
// after execution. The request register in front of the cell row takes no
// new request until the held one executes, when all cells compare and shift.
// Reset: rst_ni clears the key count and the request and result valids; slot
// keys are not reset and are only read below the count.
module sorted_set_ordered_dictionary_top import ssod_pkg::*; #(
  parameter int CAPACITY  = 16,
  parameter int KEY_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [4:0]  op_i,
  input  logic [31:0] key_i,
  input  logic [3:0]  position_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [31:0] value_o,
  output logic [4:0]  count_o
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);

  logic                 req_valid_q;
  ctl_t                 ctl_q;
  logic [KEY_WIDTH-1:0] k_q, k_in;
  logic [CNT_W-1:0]     count_q, count_d;

  logic                 out_valid_q;
  logic [1:0]           status_q, status_d;
  logic [KEY_WIDTH-1:0] value_q, value_d;

  logic                 in_fire, exec;
  logic                 ins_en, del_en, hit;
  logic [KEY_WIDTH-1:0] sel_val;

  logic [CAPACITY-1:0]  lt, gt, sel;
  logic [KEY_WIDTH-1:0] keys [CAPACITY];

  generate
    if (KEY_WIDTH <= 32) begin : g_kin_cut
      assign k_in = key_i[KEY_WIDTH-1:0];
    end else begin : g_kin_ext
      assign k_in = {{(KEY_WIDTH-32){1'b0}}, key_i};
    end
    if (KEY_WIDTH >= 32) begin : g_val_cut
      assign value_o = value_q[31:0];
    end else begin : g_val_ext
      assign value_o = {{(32-KEY_WIDTH){1'b0}}, value_q};
    end
    if (CNT_W >= 5) begin : g_cnt_cut
      assign count_o = count_q[4:0];
    end else begin : g_cnt_ext
      assign count_o = {{(5-CNT_W){1'b0}}, count_q};
    end
  endgenerate

  assign in_ready_o  = !req_valid_q;
  assign in_fire     = in_valid_i && in_ready_o;
  assign exec        = req_valid_q && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic                 l_lt, l_gt, r_lt;
      logic [KEY_WIDTH-1:0] l_key, r_key;
      if (gi == 0) begin : g_first
        assign l_lt  = 1'b1;
        assign l_gt  = 1'b0;
        assign l_key = k_q;
      end else begin : g_mid_l
        assign l_lt  = lt[gi-1];
        assign l_gt  = gt[gi-1];
        assign l_key = keys[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_last
        assign r_lt  = 1'b0;
        assign r_key = keys[gi];
      end else begin : g_mid_r
        assign r_lt  = lt[gi+1];
        assign r_key = keys[gi+1];
      end
      ssod_cell #(
        .CELL_IDX (gi),
        .KEY_WIDTH(KEY_WIDTH),
        .CNT_W    (CNT_W)
      ) u_cell (
        .clk_i      (clk_i),
        .ins_en_i   (ins_en),
        .del_en_i   (del_en),
        .ctl_i      (ctl_q),
        .k_i        (k_q),
        .count_i    (count_q),
        .left_lt_i  (l_lt),
        .left_gt_i  (l_gt),
        .left_key_i (l_key),
        .right_lt_i (r_lt),
        .right_key_i(r_key),
        .lt_o       (lt[gi]),
        .gt_o       (gt[gi]),
        .key_o      (keys[gi]),
        .sel_o      (sel[gi])
      );
    end
  endgenerate

  // at most one cell is selected: merge by OR
  always_comb begin
    sel_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      sel_val = sel_val | (sel[i] ? keys[i] : '0);
    end
  end

  assign hit    = |sel;
  assign ins_en = exec && (ctl_q.kind == K_INSERT) && !hit && (count_q < CAP);
  assign del_en = exec && ctl_q.take && hit;

  always_comb begin
    status_d = ST_ERR;
    value_d  = '0;
    count_d  = count_q;
    case (ctl_q.kind)
      K_INSERT: begin
        if (hit) begin
          status_d = ST_FALSE;
          value_d  = k_q;
        end else if (count_q < CAP) begin
          status_d = ST_OK;
          value_d  = k_q;
          count_d  = count_q + 1'b1;
        end
      end
      K_REMOVE, K_EXISTS: begin
        if (hit) begin
          status_d = ST_OK;
          value_d  = k_q;
        end else begin
          status_d = ST_FALSE;
        end
      end
      K_MIN, K_MAX, K_PRED, K_SUCC, K_READ: begin
        if (hit) begin
          status_d = ST_OK;
          value_d  = sel_val;
        end
      end
      K_CLEAR: begin
        status_d = ST_OK;
        count_d  = '0;
      end
      default: ;
    endcase
    if (ctl_q.take && hit) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      if (in_fire) begin
        req_valid_q <= 1'b1;
      end else if (exec) begin
        req_valid_q <= 1'b0;
      end
      if (exec) begin
        out_valid_q <= 1'b1;
        count_q     <= count_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // hold request and result payloads
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ctl_q <= decode_op(op_i, position_i);
      k_q   <= k_in;
    end
    if (exec) begin
      status_q <= status_d;
      value_q  <= value_d;
    end
  end

endmodule

>>> src/ssod_cell.sv
module ssod_cell import ssod_pkg::*; #(
  parameter int CELL_IDX  = 0,
  parameter int KEY_WIDTH = 32,
  parameter int CNT_W     = 5
) (
  input  logic                 clk_i,
  input  logic                 ins_en_i,
  input  logic                 del_en_i,
  input  ctl_t                 ctl_i,
  input  logic [KEY_WIDTH-1:0] k_i,
  input  logic [CNT_W-1:0]     count_i,
  input  logic                 left_lt_i,
  input  logic                 left_gt_i,
  input  logic [KEY_WIDTH-1:0] left_key_i,
  input  logic                 right_lt_i,
  input  logic [KEY_WIDTH-1:0] right_key_i,
  output logic                 lt_o,
  output logic                 gt_o,
  output logic [KEY_WIDTH-1:0] key_o,
  output logic                 sel_o
);

  localparam logic [CNT_W-1:0] ME      = CNT_W'(CELL_IDX);
  localparam logic [CNT_W-1:0] ME_NEXT = CNT_W'(CELL_IDX + 1);
  localparam logic [3:0]       POS_ME  = 4'(CELL_IDX % 16);
  localparam logic             POS_OK  = (CELL_IDX < 16);

  logic [KEY_WIDTH-1:0] key_q, key_d;
  logic                 valid, eq, shift_del, take_k, shift_ins;

  assign valid = (ME < count_i);
  assign lt_o  = valid && (key_q < k_i);
  assign gt_o  = valid && (key_q > k_i);
  assign eq    = valid && (key_q == k_i);
  assign key_o = key_q;

  // insert point is the first slot not below the key
  assign take_k    = !lt_o && left_lt_i;
  assign shift_ins = !left_lt_i;

  always_comb begin
    sel_o     = 1'b0;
    shift_del = 1'b0;
    case (ctl_i.kind)
      K_INSERT, K_EXISTS: sel_o = eq;
      K_REMOVE: begin
        sel_o     = eq;
        shift_del = !lt_o;
      end
      K_MIN: begin
        sel_o     = valid && (CELL_IDX == 0);
        shift_del = 1'b1;
      end
      K_MAX: sel_o = valid && (count_i == ME_NEXT);
      K_PRED: begin
        sel_o     = lt_o && !right_lt_i;
        shift_del = !right_lt_i;
      end
      K_SUCC: begin
        sel_o     = gt_o && !left_gt_i;
        shift_del = !(lt_o || eq);
      end
      K_READ: sel_o = valid && POS_OK && (ctl_i.pos == POS_ME);
      default: ;
    endcase
  end

  always_comb begin
    key_d = key_q;
    if (ins_en_i) begin
      if (take_k) begin
        key_d = k_i;
      end else if (shift_ins) begin
        key_d = left_key_i;
      end
    end else if (del_en_i && shift_del) begin
      key_d = right_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule
